// File: design/imu_spi_read_scheduler_unit_defines.svh
// Assertion helpers shared by the scheduler RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while arst_n is low.
`ifndef IMU_SPI_READ_SCHEDULER_UNIT_DEFINES_SVH
`define IMU_SPI_READ_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ISRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ISRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/isrs_pkg.sv
`default_nettype none

package isrs_pkg;

	// Event codes on the mode field
	localparam logic [2:0] MODE_TICK       = 3'd0;
	localparam logic [2:0] MODE_ACCEL_RDY  = 3'd1;
	localparam logic [2:0] MODE_GYRO_RDY   = 3'd2;
	localparam logic [2:0] MODE_TEMP_TICK  = 3'd3;
	localparam logic [2:0] MODE_ACCEL_DONE = 3'd4;
	localparam logic [2:0] MODE_TEMP_DONE  = 3'd5;
	localparam logic [2:0] MODE_GYRO_DONE  = 3'd6;

	// Request codes on the result
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_ACCEL = 2'd1;
	localparam logic [1:0] REQ_GYRO  = 2'd2;
	localparam logic [1:0] REQ_TEMP  = 2'd3;

	// Sensor slots in the flag vectors and start-time array
	localparam int unsigned NUM_SENSORS = 3;
	localparam logic [1:0] IDX_ACCEL = 2'd0;
	localparam logic [1:0] IDX_GYRO  = 2'd1;
	localparam logic [1:0] IDX_TEMP  = 2'd2;

	// Configuration register indexes
	localparam logic CFG_ENABLE  = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	localparam int unsigned TIMEOUT_W = 20;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd1000;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] now_us;
	} isrs_in_t;

	typedef struct packed {
		logic [1:0] request;
		logic       is_retry;
		logic       accel_sample_done;
		logic       gyro_sample_done;
	} isrs_out_t;

	typedef struct packed {
		logic [NUM_SENSORS-1:0]       ready;
		logic [NUM_SENSORS-1:0]       busy;
		logic [NUM_SENSORS-1:0][31:0] start_times;
	} isrs_state_t;

endpackage

`default_nettype wire

// File: design/isrs_arbiter.sv
`default_nettype none

module isrs_arbiter (
	input  isrs_pkg::isrs_state_t                 cur,
	input  isrs_pkg::isrs_in_t                    item,
	input  logic                                  enable,
	input  logic [isrs_pkg::TIMEOUT_W-1:0]        timeout_us,
	output isrs_pkg::isrs_state_t                 nxt,
	output isrs_pkg::isrs_out_t                   res
);

	logic [isrs_pkg::NUM_SENSORS-1:0] expired;
	logic [31:0] elapsed [isrs_pkg::NUM_SENSORS];
	logic        idle;
	logic [1:0]  req;
	logic        retry;
	logic [1:0]  slot;

	// Elapsed time per sensor, modulo 2^32
	always_comb begin
		for (int i = 0; i < isrs_pkg::NUM_SENSORS; i++) begin
			elapsed[i] = item.now_us - cur.start_times[i];
			expired[i] = elapsed[i] >= {{(32 - isrs_pkg::TIMEOUT_W){1'b0}}, timeout_us};
		end
	end

	// Pick an enabled tick's read: fresh reads first, then timed-out retries
	always_comb begin
		idle  = ~|cur.busy;
		req   = isrs_pkg::REQ_NONE;
		retry = 1'b0;
		if (item.mode == isrs_pkg::MODE_TICK && enable) begin
			if (idle && cur.ready[isrs_pkg::IDX_ACCEL]) begin
				req = isrs_pkg::REQ_ACCEL;
			end else if (idle && cur.ready[isrs_pkg::IDX_GYRO]) begin
				req = isrs_pkg::REQ_GYRO;
			end else if (idle && cur.ready[isrs_pkg::IDX_TEMP]) begin
				req = isrs_pkg::REQ_TEMP;
			end else if (cur.busy[isrs_pkg::IDX_ACCEL] && expired[isrs_pkg::IDX_ACCEL]) begin
				req   = isrs_pkg::REQ_ACCEL;
				retry = 1'b1;
			end else if (cur.busy[isrs_pkg::IDX_GYRO] && expired[isrs_pkg::IDX_GYRO]) begin
				req   = isrs_pkg::REQ_GYRO;
				retry = 1'b1;
			end else if (cur.busy[isrs_pkg::IDX_TEMP] && expired[isrs_pkg::IDX_TEMP]) begin
				req   = isrs_pkg::REQ_TEMP;
				retry = 1'b1;
			end
		end
		slot = req - 2'd1;
	end

	// Apply the event to the flags and form the result beat
	always_comb begin
		nxt = cur;
		res = '0;
		res.request  = req;
		res.is_retry = retry;
		case (item.mode)
			isrs_pkg::MODE_TICK: begin
				if (req != isrs_pkg::REQ_NONE) begin
					nxt.busy[slot]        = 1'b1;
					nxt.ready[slot]       = 1'b0;
					nxt.start_times[slot] = item.now_us;
				end
			end
			isrs_pkg::MODE_ACCEL_RDY: nxt.ready[isrs_pkg::IDX_ACCEL] = 1'b1;
			isrs_pkg::MODE_GYRO_RDY:  nxt.ready[isrs_pkg::IDX_GYRO]  = 1'b1;
			isrs_pkg::MODE_TEMP_TICK: nxt.ready[isrs_pkg::IDX_TEMP]  = 1'b1;
			isrs_pkg::MODE_ACCEL_DONE: begin
				if (enable) begin
					nxt.busy[isrs_pkg::IDX_ACCEL] = 1'b0;
					res.accel_sample_done         = 1'b1;
				end
			end
			isrs_pkg::MODE_TEMP_DONE: begin
				if (enable) begin
					nxt.busy[isrs_pkg::IDX_TEMP] = 1'b0;
				end
			end
			isrs_pkg::MODE_GYRO_DONE: begin
				if (enable) begin
					nxt.busy[isrs_pkg::IDX_GYRO] = 1'b0;
					res.gyro_sample_done         = 1'b1;
				end
			end
			default: begin
				// Unused code: no change, empty result
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/imu_spi_read_scheduler_unit.sv
// Read scheduler for three sensors sharing one serial bus.
// Input channel (in_valid / in_stall / in_data): one event beat carrying a
// mode code and a 32-bit microsecond timestamp. Output channel (out_valid /
// out_stall / out_data): exactly one result beat per event, giving the read
// issued now (if any), a retry flag and the accel / gyro sample-done pulses.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 enable, 1 timeout in microseconds); write only while no event is in flight.
// Pipeline: an event is registered on acceptance and its result is registered
// in the result register behind it, so each beat passes both registers.
// Throughput: one event per cycle unless out_stall holds a result; the flag
// update and the three elapsed-time compares are combinational in between.
// Reset: all ready and busy flags and start times clear, enable clears, the
// timeout returns to 1000 us, and both channels come up empty.
// Stall: while out_stall holds a result, the stage behind it still fills once;
// after that in_stall rises until the result beat leaves.
`default_nettype none
`include "imu_spi_read_scheduler_unit_defines.svh"

module imu_spi_read_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  isrs_pkg::isrs_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output isrs_pkg::isrs_out_t           out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [isrs_pkg::TIMEOUT_W-1:0] cfg_data
);

	logic                              valid_s1;
	isrs_pkg::isrs_in_t                item_s1;
	logic                              valid_s2;
	isrs_pkg::isrs_out_t               res_s2;
	isrs_pkg::isrs_state_t             state_q;
	isrs_pkg::isrs_state_t             state_nxt;
	isrs_pkg::isrs_out_t               res;
	logic                              enable_q;
	logic [isrs_pkg::TIMEOUT_W-1:0]    timeout_q;
	logic                              advance;

	// Result stage can take a new beat when empty or draining
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			timeout_q <= isrs_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				isrs_pkg::CFG_ENABLE:  enable_q  <= cfg_data[0];
				isrs_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	isrs_arbiter u_arbiter (
		.cur        (state_q),
		.item       (item_s1),
		.enable     (enable_q),
		.timeout_us (timeout_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	// Commit the event: advance flags and load the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	`ISRS_ASSERT_NOW(a_retry_has_req, valid_s2 && res_s2.is_retry, res_s2.request != isrs_pkg::REQ_NONE, "retry flagged without a request")
	`ISRS_ASSERT_NOW(a_one_done, valid_s2, !(res_s2.accel_sample_done && res_s2.gyro_sample_done), "two done pulses in one beat")
	`ISRS_ASSERT_NEXT(a_issue_sets_busy, advance && valid_s1 && res.request != isrs_pkg::REQ_NONE, state_q.busy != '0, "issued read left all busy flags clear")
	`ISRS_ASSERT_NEXT(a_issue_clears_ready, advance && valid_s1 && res.request == isrs_pkg::REQ_ACCEL, !state_q.ready[isrs_pkg::IDX_ACCEL], "accel ready not cleared on issue")

endmodule

`default_nettype wire
